@@ rtl/core/ulst_pkg.sv @@
package ulst_pkg;

	// table geometry
	localparam int TABLE_DEPTH_DEF = 16;
	localparam int ENTRY_W_DEF     = 40;

	// apb register map
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [0:0] REG_MAX_PEN = 1'b0;

	// field constants
	localparam logic [7:0] HOPS_NEVER    = 8'd255;
	localparam logic [3:0] PEN_SATURATE  = 4'd15;
	localparam logic [3:0] MAX_PEN_RESET = 4'd3;

	// command codes
	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_GET    = 2'd1;
	localparam logic [1:0] CMD_SWAP   = 2'd2;
	localparam logic [1:0] CMD_CLEAR  = 2'd3;

	// status codes
	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_EMPTY       = 3'd1;
	localparam logic [2:0] ST_NO_MAIN     = 3'd2;
	localparam logic [2:0] ST_NO_ELIGIBLE = 3'd3;
	localparam logic [2:0] ST_FULL        = 3'd4;

	// control sequencer
	typedef enum logic [6:0] {
		S_IDLE     = 7'b0000001,
		S_INS_SCAN = 7'b0000010,
		S_INS_WR   = 7'b0000100,
		S_GET_DATA = 7'b0001000,
		S_SW_DATA  = 7'b0010000,
		S_SEL_SCAN = 7'b0100000,
		S_RESP     = 7'b1000000
	} state_t;

endpackage

@@ rtl/core/ulst_ifs.sv @@
// command channel
interface ulst_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [7:0]  if_id;
	logic [7:0]  hop_count;
	logic [15:0] link_address;

	modport source (output valid, command, if_id, hop_count, link_address, input ready);
	modport sink (input valid, command, if_id, hop_count, link_address, output ready);
endinterface

// result channel
interface ulst_rsp_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [7:0] main_if_id;
	logic [4:0] table_size;

	modport source (output valid, status, main_if_id, table_size, input ready);
	modport sink (input valid, status, main_if_id, table_size, output ready);
endinterface

@@ rtl/core/ulst_entry_ram.sv @@
module ulst_entry_ram #(
	parameter int DEPTH = ulst_pkg::TABLE_DEPTH_DEF,
	parameter int WIDTH = ulst_pkg::ENTRY_W_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/core/upstream_link_selector_table.sv @@
// flow: insert sweeps the table for a free slot, then writes the new entry; get and swap
//   with a search sweep the table for the best link, cached get reads the cached entry, a
//   swap that empties the table drops it, and clear and early status go straight to the result
// throughput: one command at a time; the sweep of the entry memory reads one entry per
//   cycle through its single read port
// reset: arst_n clears valid bits, count, cached main link and max_penalties (to 3);
//   entry memory contents are not cleared and need no clearing pass
module upstream_link_selector_table #(
	parameter int TABLE_DEPTH = ulst_pkg::TABLE_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ulst_pkg::PADDR_W-1:0] paddr,
	input  logic [ulst_pkg::PDATA_W-1:0] pwdata,
	output logic [ulst_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	ulst_req_if.sink                    req,
	ulst_rsp_if.source                  rsp
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int EW = 8 + 8 + 16 + 4 + AW;
	localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_DEPTH);

	ulst_pkg::state_t state_q;

	logic [3:0]             max_pen_q;
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [CW-1:0]          count_q;
	logic                   main_valid_q;
	logic [AW-1:0]          main_slot_q;

	// sweep control
	logic [AW-1:0] k_q;
	logic          iss_q;
	logic          vld_s1;
	logic [AW-1:0] idx_s1;
	logic          found_q;
	logic          del_q;
	logic [AW-1:0] del_rank_q;

	// best candidate so far
	logic [3:0]    best_pen_q;
	logic [7:0]    best_hops_q;
	logic [AW-1:0] best_rank_q;
	logic [AW-1:0] best_slot_q;
	logic [7:0]    best_id_q;

	// captured insert payload and free slot
	logic [7:0]    ins_if_q;
	logic [7:0]    ins_hops_q;
	logic [15:0]   ins_addr_q;
	logic [AW-1:0] free_q;

	// pending result and output register
	logic [2:0]  res_st_q;
	logic [7:0]  res_id_q;
	logic        rsp_valid_q;
	logic [2:0]  rsp_status_q;
	logic [7:0]  rsp_id_q;
	logic [4:0]  rsp_size_q;

	// memory port
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [EW-1:0] mem_wdata;
	logic [AW-1:0] mem_raddr;
	logic [EW-1:0] mem_rdata;

	// entry fields as read
	logic [7:0]    e_if;
	logic [7:0]    e_hops;
	logic [15:0]   e_addr;
	logic [3:0]    e_pen;
	logic [AW-1:0] e_rank;

	logic          accept;
	logic          scan_st;
	logic          scan_done;
	logic          elig;
	logic          better;
	logic          upd;
	logic          take_free;
	logic [3:0]    new_pen;
	logic          del_now;
	logic          fin_found;
	logic [AW-1:0] fin_slot;
	logic [7:0]    fin_id;
	logic          out_free;
	logic          cfg_wr;
	logic          cfg_hit;
	logic [CW+4:0] size_ext;

	assign {e_if, e_hops, e_addr, e_pen, e_rank} = mem_rdata;

	ulst_entry_ram #(
		.DEPTH (TABLE_DEPTH),
		.WIDTH (EW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// apb register access
	assign pready  = 1'b1;
	assign cfg_hit = (paddr[ulst_pkg::PADDR_W-1:2] == ulst_pkg::REG_MAX_PEN);
	assign cfg_wr  = psel && penable && pwrite && cfg_hit;
	assign prdata  = cfg_hit ? {{(ulst_pkg::PDATA_W-4){1'b0}}, max_pen_q} : '0;

	// handshake
	assign req.ready = (state_q == ulst_pkg::S_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_free  = !rsp_valid_q || rsp.ready;

	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = rsp_status_q;
	assign rsp.main_if_id = rsp_id_q;
	assign rsp.table_size = rsp_size_q;
	assign size_ext       = (CW + 5)'(count_q);

	// sweep bookkeeping
	assign scan_st   = (state_q == ulst_pkg::S_INS_SCAN) || (state_q == ulst_pkg::S_SEL_SCAN);
	assign scan_done = vld_s1 && (idx_s1 == LAST_IDX);

	// selection compare: penalty, then hops, then newest
	assign elig   = valid_q[idx_s1] && (e_hops != ulst_pkg::HOPS_NEVER) && (e_pen < max_pen_q);
	assign better = !found_q || (e_pen < best_pen_q) ||
		((e_pen == best_pen_q) && ((e_hops < best_hops_q) ||
		((e_hops == best_hops_q) && (e_rank < best_rank_q))));
	assign upd    = (state_q == ulst_pkg::S_SEL_SCAN) && vld_s1 && elig && better;

	assign fin_found = found_q || upd;
	assign fin_slot  = upd ? idx_s1 : best_slot_q;
	assign fin_id    = upd ? e_if : best_id_q;

	assign take_free = (state_q == ulst_pkg::S_INS_SCAN) && vld_s1 && !valid_q[idx_s1] &&
		!found_q;

	// penalty step for the cached link
	assign new_pen = (e_pen == ulst_pkg::PEN_SATURATE) ? ulst_pkg::PEN_SATURATE : e_pen + 4'd1;
	assign del_now = (new_pen >= max_pen_q);

	// memory read address and write back
	always_comb begin
		mem_raddr = (state_q == ulst_pkg::S_IDLE) ? main_slot_q : k_q;
		mem_we    = 1'b0;
		mem_waddr = idx_s1;
		mem_wdata = mem_rdata;
		case (state_q)
			ulst_pkg::S_INS_SCAN: begin
				if (vld_s1 && valid_q[idx_s1]) begin
					mem_we    = 1'b1;
					mem_wdata = {e_if, e_hops, e_addr, e_pen, e_rank + AW'(1)};
				end
			end
			ulst_pkg::S_INS_WR: begin
				mem_we    = 1'b1;
				mem_waddr = free_q;
				mem_wdata = {ins_if_q, ins_hops_q, ins_addr_q, 4'd0, {AW{1'b0}}};
			end
			ulst_pkg::S_SW_DATA: begin
				mem_we    = 1'b1;
				mem_waddr = main_slot_q;
				mem_wdata = {e_if, e_hops, e_addr, new_pen, e_rank};
			end
			ulst_pkg::S_SEL_SCAN: begin
				// close the age gap left by a deleted link
				if (vld_s1 && del_q && valid_q[idx_s1] && (e_rank > del_rank_q)) begin
					mem_we    = 1'b1;
					mem_wdata = {e_if, e_hops, e_addr, e_pen, e_rank - AW'(1)};
				end
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ulst_pkg::S_IDLE;
			max_pen_q    <= ulst_pkg::MAX_PEN_RESET;
			valid_q      <= '0;
			count_q      <= '0;
			main_valid_q <= 1'b0;
			main_slot_q  <= '0;
			k_q          <= '0;
			iss_q        <= 1'b0;
			vld_s1       <= 1'b0;
			idx_s1       <= '0;
			found_q      <= 1'b0;
			del_q        <= 1'b0;
			del_rank_q   <= '0;
			best_pen_q   <= '0;
			best_hops_q  <= '0;
			best_rank_q  <= '0;
			best_slot_q  <= '0;
			best_id_q    <= '0;
			ins_if_q     <= '0;
			ins_hops_q   <= '0;
			ins_addr_q   <= '0;
			free_q       <= '0;
			res_st_q     <= ulst_pkg::ST_OK;
			res_id_q     <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_status_q <= ulst_pkg::ST_OK;
			rsp_id_q     <= '0;
			rsp_size_q   <= '0;
		end else begin
			if (cfg_wr) begin
				max_pen_q <= pwdata[3:0];
			end

			// read address stepping during a sweep
			vld_s1 <= scan_st && iss_q;
			idx_s1 <= k_q;
			if (scan_st && iss_q) begin
				k_q <= k_q + AW'(1);
				if (k_q == LAST_IDX) begin
					iss_q <= 1'b0;
				end
			end

			// output register: load a finished result or drop a taken transaction
			if ((state_q == ulst_pkg::S_RESP) && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				ulst_pkg::S_IDLE: begin
					if (accept) begin
						res_id_q   <= '0;
						ins_if_q   <= req.if_id;
						ins_hops_q <= req.hop_count;
						ins_addr_q <= req.link_address;
						case (req.command)
							ulst_pkg::CMD_INSERT: begin
								if (count_q == FULL_CNT) begin
									res_st_q <= ulst_pkg::ST_FULL;
									state_q  <= ulst_pkg::S_RESP;
								end else begin
									k_q     <= '0;
									iss_q   <= 1'b1;
									found_q <= 1'b0;
									state_q <= ulst_pkg::S_INS_SCAN;
								end
							end
							ulst_pkg::CMD_GET: begin
								if (count_q == '0) begin
									res_st_q <= ulst_pkg::ST_EMPTY;
									state_q  <= ulst_pkg::S_RESP;
								end else if (main_valid_q) begin
									state_q <= ulst_pkg::S_GET_DATA;
								end else begin
									k_q     <= '0;
									iss_q   <= 1'b1;
									found_q <= 1'b0;
									del_q   <= 1'b0;
									state_q <= ulst_pkg::S_SEL_SCAN;
								end
							end
							ulst_pkg::CMD_SWAP: begin
								if (count_q == '0) begin
									res_st_q <= ulst_pkg::ST_EMPTY;
									state_q  <= ulst_pkg::S_RESP;
								end else if (!main_valid_q) begin
									res_st_q <= ulst_pkg::ST_NO_MAIN;
									state_q  <= ulst_pkg::S_RESP;
								end else begin
									state_q <= ulst_pkg::S_SW_DATA;
								end
							end
							default: begin
								// clear table
								valid_q      <= '0;
								count_q      <= '0;
								main_valid_q <= 1'b0;
								res_st_q     <= ulst_pkg::ST_OK;
								state_q      <= ulst_pkg::S_RESP;
							end
						endcase
					end
				end
				ulst_pkg::S_INS_SCAN: begin
					if (take_free) begin
						free_q  <= idx_s1;
						found_q <= 1'b1;
					end
					if (scan_done) begin
						state_q <= ulst_pkg::S_INS_WR;
					end
				end
				ulst_pkg::S_INS_WR: begin
					valid_q[free_q] <= 1'b1;
					count_q         <= count_q + CW'(1);
					res_st_q        <= ulst_pkg::ST_OK;
					state_q         <= ulst_pkg::S_RESP;
				end
				ulst_pkg::S_GET_DATA: begin
					res_st_q <= ulst_pkg::ST_OK;
					res_id_q <= e_if;
					state_q  <= ulst_pkg::S_RESP;
				end
				ulst_pkg::S_SW_DATA: begin
					main_valid_q <= 1'b0;
					del_q        <= del_now;
					del_rank_q   <= e_rank;
					if (del_now) begin
						valid_q[main_slot_q] <= 1'b0;
						count_q              <= count_q - CW'(1);
					end
					if (del_now && (count_q == CW'(1))) begin
						res_st_q <= ulst_pkg::ST_EMPTY;
						state_q  <= ulst_pkg::S_RESP;
					end else begin
						k_q     <= '0;
						iss_q   <= 1'b1;
						found_q <= 1'b0;
						state_q <= ulst_pkg::S_SEL_SCAN;
					end
				end
				ulst_pkg::S_SEL_SCAN: begin
					if (upd) begin
						best_pen_q  <= e_pen;
						best_hops_q <= e_hops;
						best_rank_q <= e_rank;
						best_slot_q <= idx_s1;
						best_id_q   <= e_if;
						found_q     <= 1'b1;
					end
					if (scan_done) begin
						if (fin_found) begin
							main_slot_q  <= fin_slot;
							main_valid_q <= 1'b1;
							res_st_q     <= ulst_pkg::ST_OK;
							res_id_q     <= fin_id;
						end else begin
							res_st_q <= ulst_pkg::ST_NO_ELIGIBLE;
							res_id_q <= '0;
						end
						state_q <= ulst_pkg::S_RESP;
					end
				end
				ulst_pkg::S_RESP: begin
					if (out_free) begin
						rsp_status_q <= res_st_q;
						rsp_id_q     <= res_id_q;
						rsp_size_q   <= size_ext[4:0];
						state_q      <= ulst_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= ulst_pkg::S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ rtl/core/ulst_checker.sv @@
module ulst_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [2:0] rsp_status,
	input logic [7:0] rsp_main_if_id,
	input logic [4:0] rsp_table_size
);

	// one command in flight: accepting stalls the next one
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("command accepted while a previous one was in flight");

	// stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
		$stable(rsp_main_if_id) && $stable(rsp_table_size))
		else $error("stalled result changed");

	// status codes stay in the defined range
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_status <= ulst_pkg::ST_FULL)
		else $error("undefined status code");

	// interface id only accompanies an ok status
	a_id_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status != ulst_pkg::ST_OK) |-> rsp_main_if_id == 8'd0)
		else $error("main interface id set on a failing status");

	// empty status agrees with the reported size
	a_empty_size: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == ulst_pkg::ST_EMPTY) |-> rsp_table_size == 5'd0)
		else $error("empty status with a nonzero table size");

endmodule

bind upstream_link_selector_table ulst_checker u_ulst_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_status     (rsp.status),
	.rsp_main_if_id (rsp.main_if_id),
	.rsp_table_size (rsp.table_size)
);
